// File: rtl/fpi_pkg.sv
package fpi_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int ID_BITS_DEF    = 24;

  // Depth of the facet queue between the front and the back
  localparam int QUEUE_DEPTH = 2;

  // line_kind codes
  localparam logic [1:0] KIND_CROSS  = 2'd0;
  localparam logic [1:0] KIND_TOP    = 2'd1;
  localparam logic [1:0] KIND_BOTTOM = 2'd2;
  localparam logic [1:0] KIND_BAD    = 2'd3;

  // Next vertex around the facet
  function automatic logic [1:0] next_vertex(input logic [1:0] i);
    next_vertex = (i == 2'd2) ? 2'd0 : i + 2'd1;
  endfunction

endpackage

// File: rtl/fpi_front.sv
module fpi_front import fpi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ID_BITS    = ID_BITS_DEF,
  localparam int VW = 3 * COORD_BITS + 2 * ID_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [VW-1:0]   in_vertex,
  input  logic            in_last,
  output logic            push,
  output logic [3*VW-1:0] push_facet,
  input  logic            q_full
);

  logic [1:0]    slot;
  logic [1:0]    cur;
  logic [VW-1:0] v0;
  logic [VW-1:0] v1;
  logic          accept;

  assign cur        = (slot == 2'd3) ? 2'd0 : slot;
  assign in_ready   = (cur != 2'd2) || !q_full;
  assign accept     = in_valid && in_ready;
  assign push       = accept && (cur == 2'd2);
  assign push_facet = {in_vertex, v1, v0};

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= 2'd0;
    end else if (accept) begin
      // an early last mark drops the partial facet
      if (cur == 2'd2 || in_last) begin
        slot <= 2'd0;
      end else begin
        slot <= cur + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cur == 2'd0) begin
      v0 <= in_vertex;
    end
    if (accept && cur == 2'd1) begin
      v1 <= in_vertex;
    end
  end

endmodule

// File: rtl/fpi_queue.sv
module fpi_queue import fpi_pkg::*; #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] din,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output logic [DW-1:0] dout
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [DW-1:0] mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full      = (count == CW'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign dout      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// File: rtl/fpi_muldiv.sv
module fpi_muldiv import fpi_pkg::*; #(
  parameter int W = 33
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] d,
  output logic         done,
  output logic [W-1:0] q
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;
  localparam int CNTW = $clog2(2 * W);

  logic [1:0]     phase;
  logic [CNTW-1:0] cnt;
  logic [W-1:0]   a_r;
  logic [W-1:0]   b_r;
  logic [W-1:0]   d_r;
  logic [2*W-1:0] prod;
  logic [W-1:0]   rem;
  logic [W:0]     rem_sh;
  logic           fits;

  assign rem_sh = {rem, prod[2*W-1]};
  assign fits   = rem_sh >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        PH_IDLE: begin
          if (start) begin
            phase <= PH_MUL;
            cnt   <= '0;
          end
        end
        PH_MUL: begin
          if (cnt == CNTW'(W - 1)) begin
            phase <= PH_DIV;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        PH_DIV: begin
          if (cnt == CNTW'(2 * W - 1)) begin
            phase <= PH_IDLE;
            done  <= 1'b1;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  // Shift-and-add product, MSB of b first, then restoring division
  always_ff @(posedge clk) begin
    if (phase == PH_IDLE && start) begin
      a_r  <= a;
      b_r  <= b;
      d_r  <= d;
      prod <= '0;
      rem  <= '0;
    end else if (phase == PH_MUL) begin
      prod <= {prod[2*W-2:0], 1'b0} + (b_r[W-1] ? {{W{1'b0}}, a_r} : '0);
      b_r  <= {b_r[W-2:0], 1'b0};
    end else if (phase == PH_DIV) begin
      prod <= {prod[2*W-2:0], 1'b0};
      rem  <= fits ? W'(rem_sh - {1'b0, d_r}) : rem_sh[W-1:0];
      q    <= {q[W-2:0], fits};
    end
  end

endmodule

// File: rtl/fpi_back.sv
module fpi_back import fpi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ID_BITS    = ID_BITS_DEF,
  localparam int C  = COORD_BITS,
  localparam int VW = 3 * COORD_BITS + 2 * ID_BITS,
  localparam int W  = COORD_BITS + 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic signed [C-1:0]    slice_height,
  input  logic                   fct_valid,
  input  logic [3*VW-1:0]        fct_data,
  output logic                   fct_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [C-1:0]    start_x,
  output logic signed [C-1:0]    start_y,
  output logic signed [C-1:0]    end_x,
  output logic signed [C-1:0]    end_y,
  output logic signed [ID_BITS:0] start_vertex,
  output logic signed [ID_BITS:0] end_vertex,
  output logic signed [ID_BITS:0] start_edge,
  output logic signed [ID_BITS:0] end_edge,
  output logic [1:0]             line_kind
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PLAN = 3'd1;
  localparam logic [2:0] ST_CALC = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  // point descriptor: {crossing, vertex or edge-start index}
  typedef logic [2:0] desc_t;

  logic [2:0] state;
  logic signed [C-1:0] fx [3];
  logic signed [C-1:0] fy [3];
  logic signed [C-1:0] fz [3];
  logic [ID_BITS-1:0] fvid [3];
  logic [ID_BITS-1:0] feid [3];

  desc_t      sdesc;
  desc_t      edesc;
  logic [1:0] kind;
  logic [1:0] job;
  logic signed [C-1:0] sx;
  logic signed [C-1:0] sy;
  logic signed [C-1:0] ex;
  logic signed [C-1:0] ey;

  // ---- plan (combinational over the held facet) ----
  logic signed [C-1:0] zmin;
  logic signed [C-1:0] zmax;
  logic [1:0] first;
  logic [1:0] ord [3];
  logic [1:0] a_i;
  logic [1:0] b_i;
  logic       fl;
  logic [1:0] fla;
  logic [1:0] n;
  logic [1:0] non;
  logic [1:0] ncr;
  logic [1:0] oi0;
  logic [1:0] oi1;
  desc_t      pts [3];
  desc_t      p0;
  desc_t      p1;
  logic       below;
  logic       emit;
  logic       eqa;
  logic       eqb;

  always_comb begin
    zmin = fz[0];
    zmax = fz[0];
    for (int k = 1; k < 3; k++) begin
      if (fz[k] < zmin) zmin = fz[k];
      if (fz[k] > zmax) zmax = fz[k];
    end
    if (fz[0] == zmin) begin
      first = 2'd0;
    end else begin
      first = (fz[1] == zmin) ? 2'd1 : 2'd2;
    end
    ord[0] = first;
    ord[1] = next_vertex(first);
    ord[2] = next_vertex(ord[1]);
    below  = (fz[0] < slice_height) || (fz[1] < slice_height) || (fz[2] < slice_height);

    fl  = 1'b0;
    fla = 2'd0;
    n   = 2'd0;
    non = 2'd0;
    ncr = 2'd0;
    oi0 = 2'd0;
    oi1 = 2'd0;
    a_i = 2'd0;
    b_i = 2'd0;
    eqa = 1'b0;
    eqb = 1'b0;
    for (int k = 0; k < 3; k++) pts[k] = '0;
    for (int k = 0; k < 3; k++) begin
      a_i = ord[k];
      b_i = next_vertex(a_i);
      eqa = (fz[a_i] == slice_height);
      eqb = (fz[b_i] == slice_height);
      if (!fl) begin
        if (eqa && eqb) begin
          fl  = 1'b1;
          fla = a_i;
        end else if (eqa || eqb) begin
          if (non == 2'd0) oi0 = n;
          else oi1 = n;
          non = non + 2'd1;
          pts[n] = {1'b0, (eqa ? a_i : b_i)};
          n = n + 2'd1;
        end else if ((fz[a_i] < slice_height) != (fz[b_i] < slice_height)) begin
          pts[n] = {1'b1, a_i};
          n   = n + 2'd1;
          ncr = ncr + 2'd1;
        end
      end
    end

    // merge a vertex that was listed twice
    p0   = pts[0];
    p1   = pts[1];
    emit = (n == 2'd2);
    if (non == 2'd2 && ncr == 2'd1) begin
      emit = 1'b1;
      if (oi1 == 2'd0) begin
        p0 = pts[1];
        p1 = pts[2];
      end else if (oi1 == 2'd1) begin
        p1 = pts[2];
      end
    end else if (non == 2'd2 && ncr == 2'd0) begin
      if (fx[pts[oi0][1:0]] == fx[pts[oi1][1:0]] &&
          fy[pts[oi0][1:0]] == fy[pts[oi1][1:0]]) begin
        emit = 1'b0;
      end
    end
  end

  // ---- interpolation operands ----
  desc_t      cdesc;
  logic [1:0] ca;
  logic [1:0] cb;
  logic signed [C-1:0] va;
  logic signed [C-1:0] vb;
  logic signed [W-1:0] dx;
  logic signed [W-1:0] tt;
  logic signed [W-1:0] dd;
  logic [W-1:0] mdx;
  logic [W-1:0] mtt;
  logic [W-1:0] mdd;
  logic         neg;
  logic         md_done;
  logic [W-1:0] md_q;
  logic signed [W:0]  sq;
  logic signed [C-1:0] cres;
  logic         md_start;

  always_comb begin
    cdesc = job[1] ? edesc : sdesc;
    ca    = cdesc[1:0];
    cb    = next_vertex(ca);
    va    = job[0] ? fy[ca] : fx[ca];
    vb    = job[0] ? fy[cb] : fx[cb];
    dx    = W'(va) - W'(vb);
    tt    = W'(slice_height) - W'(fz[cb]);
    dd    = W'(fz[ca]) - W'(fz[cb]);
    mdx   = dx[W-1] ? W'(-dx) : dx;
    mtt   = tt[W-1] ? W'(-tt) : tt;
    mdd   = dd[W-1] ? W'(-dd) : dd;
    neg   = dx[W-1] ^ tt[W-1] ^ dd[W-1];
    sq    = neg ? -$signed({1'b0, md_q}) : $signed({1'b0, md_q});
    cres  = C'((W + 1)'(vb) + sq);
  end

  assign md_start = (state == ST_CALC) && cdesc[2];
  assign fct_pop  = (state == ST_IDLE) && fct_valid;

  fpi_muldiv #(.W(W)) u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .a     (mdx),
    .b     (mtt),
    .d     (mdd),
    .done  (md_done),
    .q     (md_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      job       <= 2'd0;
    end else begin
      if (out_valid && out_ready && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (fct_valid) state <= ST_PLAN;
        end
        ST_PLAN: begin
          job <= 2'd0;
          if (zmin == zmax) begin
            state <= ST_IDLE;
          end else if (fl || emit) begin
            state <= ST_CALC;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_CALC: begin
          if (cdesc[2]) begin
            state <= ST_WAIT;
          end else if (job == 2'd3) begin
            state <= ST_OUT;
          end else begin
            job <= job + 2'd1;
          end
        end
        ST_WAIT: begin
          if (md_done) begin
            if (job == 2'd3) begin
              state <= ST_OUT;
            end else begin
              job   <= job + 2'd1;
              state <= ST_CALC;
            end
          end
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fct_pop) begin
      for (int k = 0; k < 3; k++) begin
        fx[k]   <= fct_data[k*VW +: C];
        fy[k]   <= fct_data[k*VW + C +: C];
        fz[k]   <= fct_data[k*VW + 2*C +: C];
        fvid[k] <= fct_data[k*VW + 3*C +: ID_BITS];
        feid[k] <= fct_data[k*VW + 3*C + ID_BITS +: ID_BITS];
      end
    end
    if (state == ST_PLAN) begin
      if (fl) begin
        kind  <= below ? KIND_TOP : KIND_BOTTOM;
        sdesc <= below ? {1'b0, next_vertex(fla)} : {1'b0, fla};
        edesc <= below ? {1'b0, fla} : {1'b0, next_vertex(fla)};
        sx    <= below ? fx[next_vertex(fla)] : fx[fla];
        sy    <= below ? fy[next_vertex(fla)] : fy[fla];
        ex    <= below ? fx[fla] : fx[next_vertex(fla)];
        ey    <= below ? fy[fla] : fy[next_vertex(fla)];
      end else begin
        kind  <= KIND_CROSS;
        sdesc <= p1;
        edesc <= p0;
        sx    <= fx[p1[1:0]];
        sy    <= fy[p1[1:0]];
        ex    <= fx[p0[1:0]];
        ey    <= fy[p0[1:0]];
      end
    end
    if (state == ST_WAIT && md_done) begin
      case (job)
        2'd0: sx <= cres;
        2'd1: sy <= cres;
        2'd2: ex <= cres;
        default: ey <= cres;
      endcase
    end
    if (state == ST_OUT && (!out_valid || out_ready)) begin
      start_x      <= sx;
      start_y      <= sy;
      end_x        <= ex;
      end_y        <= ey;
      line_kind    <= kind;
      start_vertex <= sdesc[2] ? '1 : {1'b0, fvid[sdesc[1:0]]};
      end_vertex   <= edesc[2] ? '1 : {1'b0, fvid[edesc[1:0]]};
      start_edge   <= sdesc[2] ? {1'b0, feid[sdesc[1:0]]} : '1;
      end_edge     <= edesc[2] ? {1'b0, feid[edesc[1:0]]} : '1;
    end
  end

endmodule

// File: rtl/facet_plane_intersection.sv
// Each crossing coordinate (at most four) is computed in the one shared bit-serial
//   multiply/divide unit.
// Throughput: one vertex per cycle, unless the queue is full, into a two-facet queue;
//   the back end takes one facet at a time from the queue.
// Reset: synchronous, active high; clears slot, queue, sequencer, valid and slice_height.
module facet_plane_intersection import fpi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ID_BITS    = ID_BITS_DEF,
  localparam int DATA_W = (COORD_BITS > 32) ? 64 : 32,
  localparam int ADDR_W = (DATA_W == 64) ? 4 : 3,
  localparam int VW     = 3 * COORD_BITS + 2 * ID_BITS,
  localparam int IN_W   = ((VW + 7) / 8) * 8,
  localparam int OW     = 4 * COORD_BITS + 4 * (ID_BITS + 1),
  localparam int OUT_W  = ((OW + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // vertex stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // coord_x, coord_y, coord_z, shared_vertex_id, outgoing_edge_id
  input  logic [IN_W-1:0]   s_axis_tdata,
  input  logic              s_axis_tlast,   // third_vertex
  // segment stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // start_x, start_y, end_x, end_y, start_vertex, end_vertex, start_edge, end_edge
  output logic [OUT_W-1:0]  m_axis_tdata,
  output logic [1:0]        m_axis_tuser    // line_kind
);

  localparam int C = COORD_BITS;
  localparam int I = ID_BITS + 1;

  logic signed [C-1:0] slice_height;

  // Single register, written at every address in the lower half of the range and read back at all addresses.
  assign pready = 1'b1;
  assign prdata = DATA_W'(slice_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_height <= '0;
    end else if (psel && penable && pwrite && !paddr[ADDR_W-1]) begin
      slice_height <= pwdata[C-1:0];
    end
  end

  // Front: gather three vertices and hand a whole facet to the queue.
  logic          push;
  logic [3*VW-1:0] push_facet;
  logic          q_full;
  logic          q_not_empty;
  logic          q_pop;
  logic [3*VW-1:0] q_facet;

  fpi_front #(.COORD_BITS(COORD_BITS), .ID_BITS(ID_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_vertex  (s_axis_tdata[VW-1:0]),
    .in_last    (s_axis_tlast),
    .push       (push),
    .push_facet (push_facet),
    .q_full     (q_full)
  );

  // Queue lets the front keep taking vertices while the back works a facet.
  fpi_queue #(.DW(3 * VW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (push_facet),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .dout      (q_facet)
  );

  // Back: classify the facet against the plane, interpolate crossings, and
  // hold the result in the output register until it is taken.
  logic signed [C-1:0] start_x;
  logic signed [C-1:0] start_y;
  logic signed [C-1:0] end_x;
  logic signed [C-1:0] end_y;
  logic signed [I-1:0] start_vertex;
  logic signed [I-1:0] end_vertex;
  logic signed [I-1:0] start_edge;
  logic signed [I-1:0] end_edge;

  fpi_back #(.COORD_BITS(COORD_BITS), .ID_BITS(ID_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .slice_height (slice_height),
    .fct_valid    (q_not_empty),
    .fct_data     (q_facet),
    .fct_pop      (q_pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .start_vertex (start_vertex),
    .end_vertex   (end_vertex),
    .start_edge   (start_edge),
    .end_edge     (end_edge),
    .line_kind    (m_axis_tuser)
  );

  // Pack the segment, first field lowest, pad bits zero.
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[0 +: C]           = start_x;
    m_axis_tdata[C +: C]           = start_y;
    m_axis_tdata[2*C +: C]         = end_x;
    m_axis_tdata[3*C +: C]         = end_y;
    m_axis_tdata[4*C +: I]         = start_vertex;
    m_axis_tdata[4*C + I +: I]     = end_vertex;
    m_axis_tdata[4*C + 2*I +: I]   = start_edge;
    m_axis_tdata[4*C + 3*I +: I]   = end_edge;
  end

endmodule

// File: rtl/fpi_checker.sv
module fpi_checker import fpi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ID_BITS    = ID_BITS_DEF,
  localparam int OW     = 4 * COORD_BITS + 4 * (ID_BITS + 1),
  localparam int OUT_W  = ((OW + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             pready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic [1:0]       m_axis_tuser
);

  localparam int I  = ID_BITS + 1;
  localparam int SE = 4 * COORD_BITS + 2 * I;

  // stalled segment holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("segment changed while stalled");

  assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

  assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_axis_tvalid)
    else $error("segment valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser != KIND_BAD)
    else $error("unknown line kind");

  // facet edge lines join two vertices: both edge ids are -1
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != KIND_CROSS |->
      &m_axis_tdata[SE +: I] && &m_axis_tdata[SE + I +: I])
    else $error("facet edge line carries an edge id");

endmodule

bind facet_plane_intersection fpi_checker #(
  .COORD_BITS (COORD_BITS),
  .ID_BITS    (ID_BITS)
) u_fpi_checker (
  .clk           (clk),
  .rst           (rst),
  .pready        (pready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
